>>> rtl/core/evcp_pkg.sv
// ----------------------------------------------------------------------------
// evcp_pkg: control-pilot controller constants
// Code values, classification windows and PWM compare values for the
// charge-point pilot controller.
// ----------------------------------------------------------------------------
package evcp_pkg;

    // PWM counter period; compare values below are scaled from it
    localparam int PWM_PERIOD = 3686;

    // plug class codes
    localparam logic [2:0] PLUG_NONE    = 3'd0;
    localparam logic [2:0] PLUG_16A     = 3'd1;
    localparam logic [2:0] PLUG_32A     = 3'd2;
    localparam logic [2:0] PLUG_63A     = 3'd3;
    localparam logic [2:0] PLUG_UNKNOWN = 3'd4;

    // vehicle state codes
    localparam logic [2:0] VEH_ABSENT  = 3'd0;
    localparam logic [2:0] VEH_PRESENT = 3'd1;
    localparam logic [2:0] VEH_READY   = 3'd2;
    localparam logic [2:0] VEH_VENT    = 3'd3;
    localparam logic [2:0] VEH_UNKNOWN = 3'd4;

    // pilot output modes
    localparam logic [1:0] MODE_LOW  = 2'd0;
    localparam logic [1:0] MODE_HIGH = 2'd1;
    localparam logic [1:0] MODE_PWM  = 2'd2;

    // lock pulse requests
    localparam logic [1:0] LOCK_NONE   = 2'd0;
    localparam logic [1:0] LOCK_LOCK   = 2'd1;
    localparam logic [1:0] LOCK_UNLOCK = 2'd2;

    // socket rating codes
    localparam logic [1:0] RATE_OFF = 2'd0;
    localparam logic [1:0] RATE_16A = 2'd1;
    localparam logic [1:0] RATE_32A = 2'd2;
    localparam logic [1:0] RATE_63A = 2'd3;

    localparam logic [1:0] SOCKET_RESET = RATE_32A;

    // duty in percent per rating
    localparam int DUTY_16A = 26;
    localparam int DUTY_32A = 50;
    localparam int DUTY_63A = 89;
    localparam int DUTY_MIN = 10;
    localparam int DUTY_MAX = 90;

    // pilot mode for a given duty: below the minimum static low, above the
    // maximum static high, else PWM
    localparam logic [1:0] MODE_16A = (DUTY_16A < DUTY_MIN) ? MODE_LOW :
                                      (DUTY_16A > DUTY_MAX) ? MODE_HIGH : MODE_PWM;
    localparam logic [1:0] MODE_32A = (DUTY_32A < DUTY_MIN) ? MODE_LOW :
                                      (DUTY_32A > DUTY_MAX) ? MODE_HIGH : MODE_PWM;
    localparam logic [1:0] MODE_63A = (DUTY_63A < DUTY_MIN) ? MODE_LOW :
                                      (DUTY_63A > DUTY_MAX) ? MODE_HIGH : MODE_PWM;

    // compare values, kept to 12 bits
    localparam logic [11:0] CMP_16A   = 12'((DUTY_16A * PWM_PERIOD / 100) % 4096);
    localparam logic [11:0] CMP_32A   = 12'((DUTY_32A * PWM_PERIOD / 100) % 4096);
    localparam logic [11:0] CMP_63A   = 12'((DUTY_63A * PWM_PERIOD / 100) % 4096);
    localparam logic [11:0] CMP_RESET = 12'd1843;

    // proximity resistance windows (ohms)
    localparam logic [15:0] R_NONE_MIN = 16'd748;
    localparam logic [15:0] R_16A_LO   = 16'd612;
    localparam logic [15:0] R_32A_LO   = 16'd198;
    localparam logic [15:0] R_32A_HI   = 16'd242;
    localparam logic [15:0] R_63A_LO   = 16'd90;
    localparam logic [15:0] R_63A_HI   = 16'd110;

    // pilot voltage windows (mV)
    localparam logic [15:0] V_ABSENT_LO  = 16'd10098;
    localparam logic [15:0] V_PRESENT_LO = 16'd8262;
    localparam logic [15:0] V_READY_LO   = 16'd5565;
    localparam logic [15:0] V_READY_HI   = 16'd6801;
    localparam logic [15:0] V_VENT_LO    = 16'd4434;
    localparam logic [15:0] V_VENT_HI    = 16'd5418;

endpackage

>>> rtl/core/ev_charge_pilot_state_controller.sv
// ----------------------------------------------------------------------------
// ev_charge_pilot_state_controller: charge-point control-pilot controller
// Classifies plug and vehicle from each scan item and reprograms the pilot
// output, relays and lock pulse when the vehicle state changes.
// ----------------------------------------------------------------------------
//
//  channel | signals                                      | direction
//  --------+----------------------------------------------+----------
//  in      | i_in_valid, o_in_stall, i_pilot_millivolts,  | item in
//          | i_proximity_ohms, i_lock_open                |
//  out     | o_out_valid, i_out_stall, o_plug_class,      | item out
//          | o_vehicle_state, o_pilot_mode, o_pilot_compare,|
//          | o_power_relay, o_vent_relay, o_lock_command  |
//  cfg     | i_cfg_we, i_cfg_wdata (socket rating)        | write only
//
// Input register, window compares and state update, result register: one item per
// cycle unless the output stalls; each item passes both registers before it is offered.
// Synchronous active-low reset empties both stages and restores the state
// (vehicle absent, pilot static high, compare 1843, relays off, socket 32 A).
// An output stall holds the result register; the input register then fills
// and stalls the input side.
//
module ev_charge_pilot_state_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_pilot_millivolts,
    input  logic [15:0] i_proximity_ohms,
    input  logic        i_lock_open,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_plug_class,
    output logic [2:0]  o_vehicle_state,
    output logic [1:0]  o_pilot_mode,
    output logic [11:0] o_pilot_compare,
    output logic        o_power_relay,
    output logic        o_vent_relay,
    output logic [1:0]  o_lock_command
);
    import evcp_pkg::*;

    // socket rating register
    logic [1:0]  r_socket;

    // input stage
    logic        r_in_valid;
    logic [15:0] r_mv;
    logic [15:0] r_ohm;
    logic        r_open;

    // result stage; the controller state doubles as the result fields,
    // since it only changes when an item moves into this stage
    logic        r_out_valid;
    logic [2:0]  r_plug;
    logic [1:0]  r_lock_cmd;
    logic [2:0]  r_veh;
    logic [1:0]  r_mode;
    logic [11:0] r_cmp;
    logic        r_power;
    logic        r_vent;

    logic        adv;      // input stage moves into result stage
    logic        take_in;  // input channel handshake

    logic [2:0]  n_plug;
    logic [2:0]  n_veh;
    logic [1:0]  n_mode;
    logic [11:0] n_cmp;
    logic        n_power;
    logic        n_vent;
    logic [1:0]  n_lock_cmd;
    logic [1:0]  rate;
    logic        plug_ok;
    logic        locked;

    assign adv        = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !adv;
    assign take_in    = i_in_valid && !o_in_stall;
    assign locked     = !r_open;

    // plug from proximity resistance
    always_comb begin
        priority if (r_ohm >= R_NONE_MIN) begin
            n_plug = PLUG_NONE;
        end else if (r_ohm > R_16A_LO) begin
            n_plug = PLUG_16A;
        end else if (r_ohm > R_32A_LO && r_ohm < R_32A_HI) begin
            n_plug = PLUG_32A;
        end else if (r_ohm > R_63A_LO && r_ohm < R_63A_HI) begin
            n_plug = PLUG_63A;
        end else begin
            n_plug = PLUG_UNKNOWN;
        end
    end

    assign plug_ok = (n_plug == PLUG_16A) || (n_plug == PLUG_32A) ||
                     (n_plug == PLUG_63A);

    // vehicle from pilot voltage; absent without a usable plug
    always_comb begin
        priority if (!plug_ok) begin
            n_veh = VEH_ABSENT;
        end else if (r_mv > V_ABSENT_LO) begin
            n_veh = VEH_ABSENT;
        end else if (r_mv > V_PRESENT_LO && r_mv < V_ABSENT_LO) begin
            n_veh = VEH_PRESENT;
        end else if (r_mv > V_READY_LO && r_mv < V_READY_HI) begin
            n_veh = VEH_READY;
        end else if (r_mv > V_VENT_LO && r_mv < V_VENT_HI) begin
            n_veh = VEH_VENT;
        end else begin
            n_veh = VEH_UNKNOWN;
        end
    end

    // effective rating: lower of socket and plug (plug code equals rating
    // code for the three valid plugs)
    assign rate = (n_plug[1:0] < r_socket) ? n_plug[1:0] : r_socket;

    // reprogramming on a vehicle state change
    always_comb begin
        n_mode     = r_mode;
        n_cmp      = r_cmp;
        n_power    = r_power;
        n_vent     = r_vent;
        n_lock_cmd = LOCK_NONE;
        if (n_veh != r_veh) begin
            priority if (n_veh == VEH_ABSENT || n_veh == VEH_UNKNOWN) begin
                n_mode     = MODE_HIGH;
                n_power    = 1'b0;
                n_vent     = 1'b0;
                n_lock_cmd = locked ? LOCK_UNLOCK : LOCK_NONE;
            end else begin
                // rated PWM; a socket rating of zero leaves the pilot alone
                unique case (rate)
                    RATE_16A: begin
                        n_mode = MODE_16A;
                        if (MODE_16A == MODE_PWM) n_cmp = CMP_16A;
                    end
                    RATE_32A: begin
                        n_mode = MODE_32A;
                        if (MODE_32A == MODE_PWM) n_cmp = CMP_32A;
                    end
                    RATE_63A: begin
                        n_mode = MODE_63A;
                        if (MODE_63A == MODE_PWM) n_cmp = CMP_63A;
                    end
                    default: begin
                        n_mode = r_mode;
                    end
                endcase
                if (n_veh == VEH_PRESENT) begin
                    n_power    = 1'b0;
                    n_vent     = 1'b0;
                    n_lock_cmd = locked ? LOCK_UNLOCK : LOCK_NONE;
                end else begin
                    n_power    = 1'b1;
                    n_vent     = (n_veh == VEH_VENT);
                    n_lock_cmd = r_open ? LOCK_LOCK : LOCK_NONE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_socket    <= SOCKET_RESET;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_veh       <= VEH_ABSENT;
            r_mode      <= MODE_HIGH;
            r_cmp       <= CMP_RESET;
            r_power     <= 1'b0;
            r_vent      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_socket <= i_cfg_wdata;
            end
            if (take_in) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
                r_veh       <= n_veh;
                r_mode      <= n_mode;
                r_cmp       <= n_cmp;
                r_power     <= n_power;
                r_vent      <= n_vent;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_mv    <= i_pilot_millivolts;
            r_ohm   <= i_proximity_ohms;
            r_open  <= i_lock_open;
        end
        if (adv) begin
            r_plug     <= n_plug;
            r_lock_cmd <= n_lock_cmd;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_plug_class    = r_plug;
    assign o_vehicle_state = r_veh;
    assign o_pilot_mode    = r_mode;
    assign o_pilot_compare = r_cmp;
    assign o_power_relay   = r_power;
    assign o_vent_relay    = r_vent;
    assign o_lock_command  = r_lock_cmd;

endmodule

>>> dv/pilot_scoreboard.sv
// ----------------------------------------------------------------------------
// pilot_scoreboard: result checker for the control-pilot controller
// Watches the scan and result channels and the socket rating writes. Each
// accepted scan item is run through a local model of the controller, and
// each accepted result is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
module pilot_scoreboard (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [15:0] i_pilot_millivolts,
    input  logic [15:0] i_proximity_ohms,
    input  logic        i_lock_open,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [2:0]  i_plug_class,
    input  logic [2:0]  i_vehicle_state,
    input  logic [1:0]  i_pilot_mode,
    input  logic [11:0] i_pilot_compare,
    input  logic        i_power_relay,
    input  logic        i_vent_relay,
    input  logic [1:0]  i_lock_command,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);
    import evcp_pkg::*;

    typedef struct packed {
        logic [2:0]  plug;
        logic [2:0]  vehicle;
        logic [1:0]  mode;
        logic [11:0] compare;
        logic        power;
        logic        vent;
        logic [1:0]  lock;
    } t_pilot_result;

    // classification windows
    localparam int OHM_NONE   = 748;
    localparam int OHM_16A    = 612;
    localparam int MV_ABSENT  = 10098;
    localparam int MV_PRESENT = 8262;

    t_pilot_result expected_q[$];

    logic [1:0]  socket_q;
    logic [2:0]  vehicle_q;
    logic [1:0]  mode_q;
    logic [11:0] compare_q;
    logic        power_q;
    logic        vent_q;

    // PWM setting from the lower of socket and plug rating
    function void apply_rating(input logic [2:0] plug);
        logic [1:0] rating;
        int         duty;
        rating = socket_q;
        if (rating == RATE_OFF) begin
            return;
        end
        if (plug < rating) begin
            rating = plug[1:0];
        end
        case (rating)
            RATE_16A: duty = 26;
            RATE_32A: duty = 50;
            default:  duty = 89;
        endcase
        if (duty < 10) begin
            mode_q = MODE_LOW;
        end else if (duty > 90) begin
            mode_q = MODE_HIGH;
        end else begin
            compare_q = 12'((duty * 3686) / 100);
            mode_q    = MODE_PWM;
        end
    endfunction

    function t_pilot_result predict_scan(input logic [15:0] mv, input logic [15:0] ohm,
                                         input logic open);
        t_pilot_result r;
        logic [2:0]    plug;
        logic [2:0]    veh;
        logic [1:0]    cmd;
        if (ohm >= OHM_NONE) begin
            plug = PLUG_NONE;
        end else if (ohm > OHM_16A) begin
            plug = PLUG_16A;
        end else if (ohm > 198 && ohm < 242) begin
            plug = PLUG_32A;
        end else if (ohm > 90 && ohm < 110) begin
            plug = PLUG_63A;
        end else begin
            plug = PLUG_UNKNOWN;
        end

        if (plug == PLUG_NONE || plug == PLUG_UNKNOWN) begin
            veh = VEH_ABSENT;
        end else if (mv > MV_ABSENT) begin
            veh = VEH_ABSENT;
        end else if (mv > MV_PRESENT && mv < MV_ABSENT) begin
            veh = VEH_PRESENT;
        end else if (mv > 5565 && mv < 6801) begin
            veh = VEH_READY;
        end else if (mv > 4434 && mv < 5418) begin
            veh = VEH_VENT;
        end else begin
            veh = VEH_UNKNOWN;
        end

        cmd = LOCK_NONE;
        if (veh != vehicle_q) begin
            vehicle_q = veh;
            case (veh)
                VEH_PRESENT: begin
                    apply_rating(plug);
                    power_q = 1'b0;
                    vent_q  = 1'b0;
                    if (!open) cmd = LOCK_UNLOCK;
                end
                VEH_READY, VEH_VENT: begin
                    apply_rating(plug);
                    power_q = 1'b1;
                    vent_q  = (veh == VEH_VENT);
                    if (open) cmd = LOCK_LOCK;
                end
                default: begin
                    // full duty means static high; compare is left alone
                    mode_q  = MODE_HIGH;
                    power_q = 1'b0;
                    vent_q  = 1'b0;
                    if (!open) cmd = LOCK_UNLOCK;
                end
            endcase
        end

        r.plug    = plug;
        r.vehicle = vehicle_q;
        r.mode    = mode_q;
        r.compare = compare_q;
        r.power   = power_q;
        r.vent    = vent_q;
        r.lock    = cmd;
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_pilot_result want;
        if (!i_rst_n) begin
            expected_q.delete();
            socket_q     = SOCKET_RESET;
            vehicle_q    = VEH_ABSENT;
            mode_q       = MODE_HIGH;
            compare_q    = 12'd1843;
            power_q      = 1'b0;
            vent_q       = 1'b0;
            o_fail_count = 0;
            o_checked    = 0;
        end else begin
            if (i_cfg_we) begin
                socket_q = i_cfg_wdata;
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    $error("result item with no scan item outstanding");
                    o_fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("plug_class", int'(want.plug), int'(i_plug_class));
                    check_field("vehicle_state", int'(want.vehicle),
                                int'(i_vehicle_state));
                    check_field("pilot_mode", int'(want.mode), int'(i_pilot_mode));
                    check_field("pilot_compare", int'(want.compare),
                                int'(i_pilot_compare));
                    check_field("power_relay", int'(want.power), int'(i_power_relay));
                    check_field("vent_relay", int'(want.vent), int'(i_vent_relay));
                    check_field("lock_command", int'(want.lock), int'(i_lock_command));
                    o_checked++;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_q.push_back(predict_scan(i_pilot_millivolts, i_proximity_ohms,
                                                  i_lock_open));
            end
        end
        o_pending = expected_q.size();
    end

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the control-pilot state controller
// Drives scan items through the block in bursts against a receiver that
// stalls on its own pattern, steps the socket rating through all codes and
// leaves checking to pilot_scoreboard. Prints the verdict at the end.
// ----------------------------------------------------------------------------
module tb_top;
    import evcp_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_wdata;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [15:0] i_pilot_millivolts;
    logic [15:0] i_proximity_ohms;
    logic        i_lock_open;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [2:0]  o_plug_class;
    logic [2:0]  o_vehicle_state;
    logic [1:0]  o_pilot_mode;
    logic [11:0] o_pilot_compare;
    logic        o_power_relay;
    logic        o_vent_relay;
    logic [1:0]  o_lock_command;

    int fail_count;
    int pending;
    int checked;
    int scans_sent;

    // long output hold-offs: the stimulus raises a request, the receiver
    // serves it in its own process
    int hold_req;
    int hold_done;

    ev_charge_pilot_state_controller DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_pilot_millivolts (i_pilot_millivolts),
        .i_proximity_ohms   (i_proximity_ohms),
        .i_lock_open        (i_lock_open),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_plug_class       (o_plug_class),
        .o_vehicle_state    (o_vehicle_state),
        .o_pilot_mode       (o_pilot_mode),
        .o_pilot_compare    (o_pilot_compare),
        .o_power_relay      (o_power_relay),
        .o_vent_relay       (o_vent_relay),
        .o_lock_command     (o_lock_command)
    );

    pilot_scoreboard checker_i (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_in_valid         (i_in_valid),
        .i_in_stall         (o_in_stall),
        .i_pilot_millivolts (i_pilot_millivolts),
        .i_proximity_ohms   (i_proximity_ohms),
        .i_lock_open        (i_lock_open),
        .i_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .i_plug_class       (o_plug_class),
        .i_vehicle_state    (o_vehicle_state),
        .i_pilot_mode       (o_pilot_mode),
        .i_pilot_compare    (o_pilot_compare),
        .i_power_relay      (o_power_relay),
        .i_vent_relay       (o_vent_relay),
        .i_lock_command     (o_lock_command),
        .o_fail_count       (fail_count),
        .o_pending          (pending),
        .o_checked          (checked)
    );

    initial begin : clock_gen
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop: far beyond the slowest legal run
    initial begin : watchdog
        #3_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Offer one scan item from the next falling edge and hold it until the
    // block takes it. Sampling in the active region of the rising edge sees
    // the stall as it stood before the edge.
    task automatic send_scan(input logic [15:0] mv, input logic [15:0] ohm,
                             input logic open);
        @(negedge i_clk);
        i_in_valid         <= 1'b1;
        i_pilot_millivolts <= mv;
        i_proximity_ohms   <= ohm;
        i_lock_open        <= open;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        scans_sent++;
    endtask

    // idle the sender; payload wanders while valid is low
    task automatic gap(input int n);
        if (n > 0) begin
            @(negedge i_clk);
            i_in_valid         <= 1'b0;
            i_pilot_millivolts <= 16'($urandom);
            i_proximity_ohms   <= 16'($urandom);
            i_lock_open        <= 1'($urandom);
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    // socket rating is only changed with the block drained; every scan item
    // gives a result, so once none is pending the block is empty
    task automatic write_socket(input logic [1:0] rating);
        gap(1);
        wait (pending == 0);
        repeat (4) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= rating;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Receiver: stretches of no stall, light stall and heavy stall, plus the
    // long hold-offs on request. One assignment per falling edge.
    initial begin : receiver
        int mode;
        int seg;
        int hold_left;
        mode        = 0;
        seg         = 0;
        hold_left   = 0;
        hold_done   = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else if (hold_req != hold_done) begin
                hold_done++;
                hold_left = 79;
                i_out_stall <= 1'b1;
            end else begin
                if (seg == 0) begin
                    mode = $urandom_range(0, 2);
                    seg  = $urandom_range(10, 60);
                end
                seg--;
                case (mode)
                    0:       i_out_stall <= 1'b0;
                    1:       i_out_stall <= ($urandom_range(0, 99) < 30);
                    default: i_out_stall <= ($urandom_range(0, 99) < 70);
                endcase
            end
        end
    end

    initial begin : stimulus
        logic [1:0]  phase_rating [8];
        logic [2:0]  sess_plug;
        logic [2:0]  veh_pick;
        logic [15:0] mv;
        logic [15:0] ohm;
        int          sess_left;
        int          n;
        int          burst;

        phase_rating       = '{RATE_63A, RATE_16A, RATE_OFF, RATE_32A,
                               RATE_63A, RATE_OFF, RATE_16A, RATE_32A};
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_wdata        = RATE_32A;
        i_in_valid         = 1'b0;
        i_pilot_millivolts = 16'd0;
        i_proximity_ohms   = 16'd0;
        i_lock_open        = 1'b0;
        hold_req           = 0;
        scans_sent         = 0;
        sess_left          = 0;
        sess_plug          = PLUG_NONE;
        veh_pick           = VEH_ABSENT;

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed: window edges and state transitions, socket at 32 A, then 63 A, off, 16 A ----
        send_scan(16'd12000, 16'd65535, 1'b1); // no plug, stays absent
        send_scan(16'd9000,  16'd747,   1'b1); // 16 A plug present, 16 A duty
        send_scan(16'd6000,  16'd747,   1'b0); // ready while locked: no pulse
        send_scan(16'd5000,  16'd613,   1'b1); // ventilation, lock pulse
        send_scan(16'd5000,  16'd613,   1'b1); // unchanged, nothing moves
        send_scan(16'd0,     16'd613,   1'b0); // unknown voltage, unlock
        send_scan(16'd65535, 16'd748,   1'b0); // plug gone, back to absent
        send_scan(16'd8263,  16'd241,   1'b0); // 32 A present, unlock
        send_scan(16'd10097, 16'd199,   1'b1); // present held
        send_scan(16'd5566,  16'd199,   1'b1); // ready, lock pulse
        send_scan(16'd6800,  16'd109,   1'b0); // plug swap, state held
        send_scan(16'd10098, 16'd91,    1'b0); // exactly on the absent edge
        send_scan(16'd10099, 16'd91,    1'b0); // just above it: absent
        send_scan(16'd4435,  16'd91,    1'b1); // 63 A plug capped by 32 A socket
        send_scan(16'd5417,  16'd242,   1'b1); // resistance gaps: unknown plug
        send_scan(16'd5418,  16'd110,   1'b1);
        send_scan(16'd4434,  16'd90,    1'b0);
        send_scan(16'd8262,  16'd198,   1'b0);
        send_scan(16'd5565,  16'd612,   1'b1);
        write_socket(RATE_63A);
        send_scan(16'd9000,  16'd100,   1'b0); // full 63 A duty
        write_socket(RATE_OFF);
        send_scan(16'd6500,  16'd700,   1'b1); // socket off: pilot untouched
        send_scan(16'd12000, 16'd0,     1'b0);
        write_socket(RATE_16A);
        send_scan(16'd5000,  16'd100,   1'b1); // 16 A socket caps 63 A plug
        send_scan(16'd32768, 16'd65535, 1'b0);

        // ---- random: plug sessions with vehicle walks, plus noise ----
        for (int ph = 0; ph < 8; ph++) begin
            write_socket(phase_rating[ph]);
            // hold the output while the sender keeps pushing
            if (ph == 2 || ph == 5) begin
                hold_req++;
            end
            n = 0;
            while (n < 200) begin
                burst = $urandom_range(1, 24);
                repeat (burst) begin
                    if (sess_left == 0) begin
                        sess_left = $urandom_range(2, 12);
                        if ($urandom_range(0, 9) < 7) begin
                            sess_plug = 3'($urandom_range(1, 3));
                        end else begin
                            sess_plug = $urandom_range(0, 1) ? PLUG_NONE : PLUG_UNKNOWN;
                        end
                    end
                    sess_left--;
                    if ($urandom_range(0, 99) < 15) begin
                        mv  = 16'($urandom);
                        ohm = 16'($urandom);
                    end else begin
                        if ($urandom_range(0, 99) < 55) begin
                            veh_pick = 3'($urandom_range(0, 4));
                        end
                        case (sess_plug)
                            PLUG_NONE: ohm = 16'($urandom_range(748, 65535));
                            PLUG_16A:  ohm = 16'($urandom_range(613, 747));
                            PLUG_32A:  ohm = 16'($urandom_range(199, 241));
                            PLUG_63A:  ohm = 16'($urandom_range(91, 109));
                            default: begin
                                case ($urandom_range(0, 2))
                                    0:       ohm = 16'($urandom_range(0, 90));
                                    1:       ohm = 16'($urandom_range(110, 198));
                                    default: ohm = 16'($urandom_range(242, 612));
                                endcase
                            end
                        endcase
                        case (veh_pick)
                            VEH_ABSENT:  mv = 16'($urandom_range(10099, 65535));
                            VEH_PRESENT: mv = 16'($urandom_range(8263, 10097));
                            VEH_READY:   mv = 16'($urandom_range(5566, 6800));
                            VEH_VENT:    mv = 16'($urandom_range(4435, 5417));
                            default: begin
                                case ($urandom_range(0, 3))
                                    0:       mv = 16'($urandom_range(0, 4434));
                                    1:       mv = 16'($urandom_range(5418, 5565));
                                    2:       mv = 16'($urandom_range(6801, 8262));
                                    default: mv = 16'd10098;
                                endcase
                            end
                        endcase
                    end
                    send_scan(mv, ohm, 1'($urandom));
                    n++;
                end
                // one phase runs back to back
                if (ph != 3) begin
                    gap($urandom_range(0, 6));
                end
            end
        end

        // drain, then let the pipeline settle
        gap(1);
        wait (pending == 0);
        repeat (10) @(negedge i_clk);

        $display("Covered %0d scan items over socket ratings off, 16, 32 and 63 A,",
                 scans_sent);
        $display("with bursty input, long output hold-offs; %0d results compared.", checked);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
